// ----- rtl/core/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assertion macros
// clocked assertions that compile away in synthesis
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// checked on every clk edge, off while rst_n is low
`define STHP_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
// checked on every clk edge, also during reset
`define STHP_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");
`else
`define STHP_ASSERT(lbl, prop)
`define STHP_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// ----- rtl/core/sthp_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sthp_pkg
// shared types, character codes and the hex digit decoder for the parser
// ---------------------------------------------------------------------------
package sthp_pkg;

    localparam logic [7:0] CH_STX   = 8'h02;
    localparam logic [7:0] CH_ETX   = 8'h03;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;

    localparam int unsigned ZERO_RUN_LEN = 8;
    localparam int unsigned ZR_W         = 4;
    localparam int unsigned DCNT_W       = 4;
    localparam int unsigned VAL_W        = 32;
    localparam int unsigned IDX_W        = 10;
    localparam int unsigned CNT_W        = 11;

    typedef enum logic [2:0] {
        PH_WAIT_ZERO  = 3'd0,
        PH_SKIP_ONE   = 3'd1,
        PH_SKIP_START = 3'd2,
        PH_SKIP_STEP  = 3'd3,
        PH_COUNT      = 3'd4,
        PH_DATA       = 3'd5,
        PH_IDLE       = 3'd6
    } phase_t;

    typedef enum logic [1:0] {
        TK_HOLD  = 2'd0,
        TK_TAKE  = 2'd1,
        TK_CLEAR = 2'd2
    } tok_cmd_t;

    typedef struct packed {
        logic             ok;
        logic [VAL_W-1:0] acc;
    } tok_stat_t;

    typedef struct packed {
        logic             channel;
        logic [IDX_W-1:0] point_index;
        logic [VAL_W-1:0] value;
        logic             last_point;
        logic [CNT_W-1:0] point_count;
    } res_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] nib;
    } hex_t;

    function automatic hex_t hex_decode(input logic [7:0] c);
        hex_t h;
        h.ok  = 1'b1;
        h.nib = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            h.nib = c[3:0];
        end
        else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
        begin
            // 'A'..'F' and 'a'..'f' share the low bits 1..6
            h.nib = c[3:0] + 4'd9;
        end
        else
        begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

endpackage

// ----- rtl/core/sthp_token.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sthp_token
// hex token accumulator: digit shift-in, digit count and bad-token flag
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sthp_token #(
    parameter int MAX_HEX_DIGITS = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  sthp_pkg::tok_cmd_t  cmd,
    input  logic [7:0]          byte_in,
    output sthp_pkg::tok_stat_t stat
);

    logic [sthp_pkg::VAL_W-1:0]  acc_reg, acc_next;
    logic [sthp_pkg::DCNT_W-1:0] dcnt_reg, dcnt_next;
    logic                        bad_reg, bad_next;
    sthp_pkg::hex_t              hex;

    assign hex = sthp_pkg::hex_decode(byte_in);

    always_comb
    begin
        acc_next  = acc_reg;
        dcnt_next = dcnt_reg;
        bad_next  = bad_reg;
        case (cmd)
            sthp_pkg::TK_CLEAR:
            begin
                acc_next  = '0;
                dcnt_next = '0;
                bad_next  = 1'b0;
            end
            sthp_pkg::TK_TAKE:
            begin
                if (!hex.ok)
                begin
                    bad_next = 1'b1;
                end
                else if (dcnt_reg < sthp_pkg::DCNT_W'(MAX_HEX_DIGITS))
                begin
                    acc_next  = {acc_reg[sthp_pkg::VAL_W-5:0], hex.nib};
                    dcnt_next = dcnt_reg + 1'b1;
                end
                else
                begin
                    bad_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            dcnt_reg <= '0;
            bad_reg  <= 1'b0;
        end
        else
        begin
            acc_reg  <= acc_next;
            dcnt_reg <= dcnt_next;
            bad_reg  <= bad_next;
        end
    end

    // good token: digits seen, none bad, fits in 31 bits
    assign stat.ok  = !bad_reg && (dcnt_reg != '0) && !acc_reg[sthp_pkg::VAL_W-1];
    assign stat.acc = acc_reg;

    `STHP_ASSERT(a_dcnt_bound, dcnt_reg <= sthp_pkg::DCNT_W'(MAX_HEX_DIGITS))
    `STHP_ASSERT(a_clear_empties, (cmd == sthp_pkg::TK_CLEAR) |=> (dcnt_reg == '0 && !bad_reg))

endmodule

// ----- rtl/core/sthp_ctrl.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sthp_ctrl
// telegram phase sequencer, point counting and result formatting
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sthp_ctrl #(
    parameter int MAX_POINTS = 1024,
    parameter int PW         = 11
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  logic [7:0]          byte_in,
    input  sthp_pkg::tok_stat_t tok,
    output sthp_pkg::tok_cmd_t  tok_cmd,
    output logic                res_valid,
    output sthp_pkg::res_t      res
);

    sthp_pkg::phase_t              phase_reg, phase_next;
    logic [sthp_pkg::ZR_W-1:0]     zr_reg, zr_next;
    logic [PW-1:0]                 exp_reg, exp_next;
    logic [PW-1:0]                 seen_reg, seen_next;
    logic                          ch_reg, ch_next;
    logic                          done;
    logic [PW-1:0]                 slot_inc;
    logic                          count_ok;
    logic [PW+sthp_pkg::IDX_W-1:0] idx_ext;
    logic [PW+sthp_pkg::CNT_W-1:0] cnt_ext;

    assign slot_inc = seen_reg + 1'b1;
    assign count_ok = tok.ok && (tok.acc <= sthp_pkg::VAL_W'(MAX_POINTS));
    assign idx_ext  = {{sthp_pkg::IDX_W{1'b0}}, seen_reg};
    assign cnt_ext  = {{sthp_pkg::CNT_W{1'b0}}, exp_reg};

    // result fields for the token in flight; res_valid says whether it counts
    always_comb
    begin
        res.channel     = ch_reg;
        res.point_index = idx_ext[sthp_pkg::IDX_W-1:0];
        res.value       = ch_reg ? tok.acc : {tok.acc[sthp_pkg::VAL_W-2:0], 1'b0};
        res.last_point  = (slot_inc >= exp_reg);
        res.point_count = cnt_ext[sthp_pkg::CNT_W-1:0];
    end

    always_comb
    begin
        phase_next = phase_reg;
        zr_next    = zr_reg;
        exp_next   = exp_reg;
        seen_next  = seen_reg;
        ch_next    = ch_reg;
        tok_cmd    = sthp_pkg::TK_HOLD;
        res_valid  = 1'b0;
        done       = 1'b0;
        if (fire)
        begin
            if (byte_in == sthp_pkg::CH_STX)
            begin
                phase_next = sthp_pkg::PH_WAIT_ZERO;
                zr_next    = '0;
                exp_next   = '0;
                seen_next  = '0;
                ch_next    = 1'b0;
                tok_cmd    = sthp_pkg::TK_CLEAR;
            end
            else if (byte_in == sthp_pkg::CH_ETX)
            begin
                // close a pending data token, then idle until the next start
                res_valid  = (phase_reg == sthp_pkg::PH_DATA) && tok.ok;
                phase_next = sthp_pkg::PH_IDLE;
                tok_cmd    = sthp_pkg::TK_CLEAR;
            end
            else
            begin
                unique case (phase_reg)
                    sthp_pkg::PH_WAIT_ZERO:
                    begin
                        if (byte_in == sthp_pkg::CH_ZERO)
                        begin
                            if (zr_reg == sthp_pkg::ZR_W'(sthp_pkg::ZERO_RUN_LEN - 1))
                            begin
                                zr_next    = '0;
                                phase_next = sthp_pkg::PH_SKIP_ONE;
                            end
                            else
                            begin
                                zr_next = zr_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            zr_next = '0;
                        end
                    end
                    sthp_pkg::PH_SKIP_ONE:
                    begin
                        phase_next = sthp_pkg::PH_SKIP_START;
                    end
                    sthp_pkg::PH_SKIP_START:
                    begin
                        if (byte_in == sthp_pkg::CH_SPACE)
                        begin
                            phase_next = sthp_pkg::PH_SKIP_STEP;
                        end
                    end
                    sthp_pkg::PH_SKIP_STEP:
                    begin
                        if (byte_in == sthp_pkg::CH_SPACE)
                        begin
                            phase_next = sthp_pkg::PH_COUNT;
                            tok_cmd    = sthp_pkg::TK_CLEAR;
                        end
                    end
                    sthp_pkg::PH_COUNT:
                    begin
                        if (byte_in == sthp_pkg::CH_SPACE)
                        begin
                            exp_next  = count_ok ? tok.acc[PW-1:0] : '0;
                            seen_next = '0;
                            tok_cmd   = sthp_pkg::TK_CLEAR;
                            // bad or zero count ends the channel at once
                            if (!count_ok || tok.acc == '0)
                            begin
                                done = 1'b1;
                            end
                            else
                            begin
                                phase_next = sthp_pkg::PH_DATA;
                            end
                        end
                        else
                        begin
                            tok_cmd = sthp_pkg::TK_TAKE;
                        end
                    end
                    sthp_pkg::PH_DATA:
                    begin
                        if (byte_in == sthp_pkg::CH_SPACE)
                        begin
                            res_valid = tok.ok;
                            tok_cmd   = sthp_pkg::TK_CLEAR;
                            seen_next = slot_inc;
                            done      = (slot_inc >= exp_reg);
                        end
                        else
                        begin
                            tok_cmd = sthp_pkg::TK_TAKE;
                        end
                    end
                    default:
                    begin
                        phase_next = sthp_pkg::PH_IDLE;
                    end
                endcase
                if (done)
                begin
                    if (!ch_reg)
                    begin
                        phase_next = sthp_pkg::PH_WAIT_ZERO;
                        zr_next    = '0;
                        exp_next   = '0;
                        seen_next  = '0;
                        ch_next    = 1'b1;
                    end
                    else
                    begin
                        phase_next = sthp_pkg::PH_IDLE;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= sthp_pkg::PH_WAIT_ZERO;
            zr_reg    <= '0;
            exp_reg   <= '0;
            seen_reg  <= '0;
            ch_reg    <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            zr_reg    <= zr_next;
            exp_reg   <= exp_next;
            seen_reg  <= seen_next;
            ch_reg    <= ch_next;
        end
    end

    `STHP_ASSERT(a_res_in_data, res_valid |-> (phase_reg == sthp_pkg::PH_DATA))
    `STHP_ASSERT(a_data_slots_left, (phase_reg == sthp_pkg::PH_DATA) |-> (seen_reg < exp_reg))
    `STHP_ASSERT(a_zero_run_bound, zr_reg < sthp_pkg::ZR_W'(sthp_pkg::ZERO_RUN_LEN))

endmodule

// ----- rtl/core/sthp_outq.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sthp_outq
// two-entry result buffer between the parser and the output channel
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sthp_outq (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  sthp_pkg::res_t push_data,
    input  logic           pop,
    output logic           full,
    output logic           not_empty,
    output sthp_pkg::res_t head
);

    sthp_pkg::res_t mem_reg [2];
    logic           wr_ptr_reg, rd_ptr_reg;
    logic [1:0]     count_reg, count_next;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = mem_reg[rd_ptr_reg];

    `STHP_ASSERT_ALWAYS(a_count_bound, count_reg <= 2'd2)
    `STHP_ASSERT(a_no_push_full, full |-> !push)
    `STHP_ASSERT(a_ptr_count, (count_reg == 2'd1) |-> (wr_ptr_reg != rd_ptr_reg))

endmodule

// ----- rtl/core/scan_telegram_hex_parser_top.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// scan_telegram_hex_parser_top
// ascii scan telegram parser, one character per item
// ---------------------------------------------------------------------------
// input channel: in_valid / in_ready carry byte_in, one telegram character
// per item. 0x02 restarts a telegram, 0x20 separates tokens, 0x03 ends it.
// output channel: out_valid / out_ready carry one parsed point per item:
// channel, point_index, value (doubled on the distance channel),
// last_point and point_count.
// throughput: one byte per cycle while in_ready is high, set by the single
// phase/token update done between the token registers and the result buffer.
// output: a point enters the result buffer when the separator or end byte
// that closes its token is accepted, and is offered once it heads the buffer.
// stall: results sit in a two-entry buffer; bytes keep flowing while it
// has room, and in_ready drops only while both entries are held.
// reset: the buffer empties and parsing starts as if 0x02 had arrived.
// ---------------------------------------------------------------------------

module scan_telegram_hex_parser_top #(
    parameter int MAX_POINTS     = 1024,
    parameter int MAX_HEX_DIGITS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  byte_in,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        channel,
    output logic [9:0]  point_index,
    output logic [31:0] value,
    output logic        last_point,
    output logic [10:0] point_count
);

    localparam int PW = $clog2(MAX_POINTS + 1);

    logic                fire;
    logic                full;
    logic                res_valid;
    sthp_pkg::res_t      res;
    sthp_pkg::res_t      head;
    sthp_pkg::tok_cmd_t  tok_cmd;
    sthp_pkg::tok_stat_t tok;

    assign in_ready = !full;
    assign fire     = in_valid && in_ready;

    sthp_token #(
        .MAX_HEX_DIGITS (MAX_HEX_DIGITS)
    ) u_token (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (tok_cmd),
        .byte_in (byte_in),
        .stat    (tok)
    );

    sthp_ctrl #(
        .MAX_POINTS (MAX_POINTS),
        .PW         (PW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .byte_in   (byte_in),
        .tok       (tok),
        .tok_cmd   (tok_cmd),
        .res_valid (res_valid),
        .res       (res)
    );

    sthp_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .pop       (out_valid && out_ready),
        .full      (full),
        .not_empty (out_valid),
        .head      (head)
    );

    assign channel     = head.channel;
    assign point_index = head.point_index;
    assign value       = head.value;
    assign last_point  = head.last_point;
    assign point_count = head.point_count;

endmodule
